>>> rtl/core/order_book_matcher_macros.svh
// Assertion helpers shared by the order book
`ifndef ORDER_BOOK_MATCHER_MACROS_SVH
`define ORDER_BOOK_MATCHER_MACROS_SVH

// Implication checked on every clock edge outside reset
`define OBM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define OBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/obm_pkg.sv
package obm_pkg;

  localparam int unsigned POOL_ORDERS_DEF  = 16;
  localparam int unsigned PRICE_LEVELS_DEF = 16384;
  localparam int unsigned MAX_RESULTS      = 33;

  localparam logic MODE_NEW    = 1'b0;
  localparam logic MODE_CANCEL = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic [1:0] TYPE_LIMIT  = 2'd0;
  localparam logic [1:0] TYPE_MARKET = 2'd1;

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [1:0] ST_FILLED    = 2'd0;
  localparam logic [1:0] ST_RESTING   = 2'd1;
  localparam logic [1:0] ST_CANCELLED = 2'd2;

  // One resting order as held by a cell
  typedef struct packed {
    logic        valid;
    logic [31:0] order_ref;
    logic        side;
    logic [15:0] price;
    logic [31:0] original;
    logic [31:0] remaining;
    logic [31:0] rank;
  } entry_t;

  // Search query broadcast to every cell
  typedef struct packed {
    logic        cancel;
    logic [31:0] order_ref;
    logic        side;
    logic        market;
    logic [15:0] price;
    logic [31:0] counter;
  } query_t;

  // Candidate passed along the chain
  typedef struct packed {
    logic        found;
    logic [4:0]  slot;
    logic [15:0] price;
    logic [31:0] age;
  } cand_t;

  typedef struct packed {
    logic        record_kind;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [31:0] report_id;
    logic [1:0]  report_status;
    logic        report_side;
    logic [15:0] deal_price;
    logic [31:0] deal_quantity;
    logic [31:0] left_quantity;
    logic [47:0] trade_time;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] order_ref;
    logic        side;
    logic [1:0]  order_type;
    logic [15:0] limit_price;
    logic [31:0] order_quantity;
    logic [47:0] arrival_time;
  } request_t;

endpackage

>>> rtl/core/obm_if.sv
interface obm_req_if
  import obm_pkg::*;
();
  logic     valid;
  logic     ready;
  request_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface obm_res_if
  import obm_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/obm_cell.sv
// One pool slot: holds an entry and merges its bid into the passing candidate
module obm_cell
  import obm_pkg::*;
#(
  parameter logic [4:0] SLOT = 5'd0
) (
  input  logic   clk,
  input  logic   rst,
  input  query_t query,
  input  cand_t  cand_in,
  output cand_t  cand_out,
  input  logic   wr_en,
  input  entry_t wr_entry,
  output entry_t entry
);

  logic        eligible;
  logic [31:0] age;
  logic        better;

  // Storage; only valid is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (wr_en) begin
      entry <= wr_entry;
    end
  end

  // Local compare against the candidate from the previous cell
  always_comb begin
    age = query.counter - entry.rank;
    if (query.cancel) begin
      eligible = entry.valid && (entry.order_ref == query.order_ref);
      better   = !cand_in.found || (age < cand_in.age);
    end else begin
      eligible = entry.valid && (entry.side != query.side);
      if (!query.market) begin
        if (query.side == SIDE_BUY && query.price < entry.price) eligible = 1'b0;
        if (query.side == SIDE_SELL && query.price > entry.price) eligible = 1'b0;
      end
      if (!cand_in.found) better = 1'b1;
      else if (entry.price == cand_in.price) better = age > cand_in.age;
      else if (query.side == SIDE_BUY) better = entry.price < cand_in.price;
      else better = entry.price > cand_in.price;
    end
  end

  // Registered hand-off to the next cell
  always_ff @(posedge clk) begin
    if (eligible && better) begin
      cand_out.found <= 1'b1;
      cand_out.slot  <= SLOT;
      cand_out.price <= entry.price;
      cand_out.age   <= age;
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

>>> rtl/core/order_book_matcher.sv
// One request at a time. A book search walks the POOL_ORDERS cells one after another;
// each fill emits a trade, then a filled report if the resting order empties. A new
// order ends with its final report, a cancel that finds its order with a cancelled
// report, and an invalid order is reported cancelled without a search. Results leave
// through one output register and its stalls hold the controller.
// Reset clears all entry valid bits, the arrival counter and the controller.
module order_book_matcher
  import obm_pkg::*;
#(
  parameter int unsigned POOL_ORDERS  = POOL_ORDERS_DEF,
  parameter int unsigned PRICE_LEVELS = PRICE_LEVELS_DEF
) (
  input logic        clk,
  input logic        rst,
  obm_req_if.sink    req,
  obm_res_if.source  res
);

  `include "order_book_matcher_macros.svh"

  localparam int unsigned IW = (POOL_ORDERS > 1) ? $clog2(POOL_ORDERS) : 1;
  localparam int unsigned CW = $clog2(POOL_ORDERS + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_EMIT, S_FINAL
  } state_t;

  state_t      state;
  request_t    cur;
  logic [31:0] left;
  logic [31:0] counter;
  logic [5:0]  n_res;
  logic [CW-1:0] cyc;
  logic        fill_report;
  logic [IW-1:0] hit;
  logic [31:0] fill;

  query_t query;
  cand_t  chain [POOL_ORDERS+1];
  entry_t ent [POOL_ORDERS];
  logic   wr_en [POOL_ORDERS];
  entry_t wr_entry;
  logic [IW-1:0] wr_slot;
  logic   wr_go;
  logic   wr_load;
  entry_t hit_e;
  entry_t dec_entry;

  logic          free_found;
  logic [IW-1:0] free_slot;

  logic       bad_order;
  logic       rest_ok;
  logic [1:0] final_status;
  logic       out_free;
  logic       out_load;

  result_t out;
  logic    out_valid;

  function automatic result_t report_rec(logic [31:0] rid, logic [1:0] status, logic sd,
                                         logic [15:0] price, logic [31:0] qty,
                                         logic [31:0] left_q, logic fin);
    result_t r;
    r = '0;
    r.record_kind   = KIND_REPORT;
    r.report_id     = rid;
    r.report_status = status;
    r.report_side   = sd;
    r.deal_price    = price;
    r.deal_quantity = qty;
    r.left_quantity = left_q;
    r.last          = fin;
    return r;
  endfunction

  function automatic result_t trade_rec(logic [31:0] buyer, logic [31:0] seller,
                                        logic [15:0] price, logic [31:0] qty,
                                        logic [47:0] tstamp);
    result_t r;
    r = '0;
    r.record_kind   = KIND_TRADE;
    r.buyer_id      = buyer;
    r.seller_id     = seller;
    r.deal_price    = price;
    r.deal_quantity = qty;
    r.trade_time    = tstamp;
    return r;
  endfunction

  assign query.cancel    = cur.mode;
  assign query.order_ref = cur.order_ref;
  assign query.side      = cur.side;
  assign query.market    = (cur.order_type == TYPE_MARKET);
  assign query.price     = cur.limit_price;
  assign query.counter   = counter;

  assign chain[0] = '0;

  // Row of cells
  for (genvar i = 0; i < POOL_ORDERS; i++) begin : g_cell
    obm_cell #(.SLOT(5'(i))) u_cell (
      .clk     (clk),
      .rst     (rst),
      .query   (query),
      .cand_in (chain[i]),
      .cand_out(chain[i+1]),
      .wr_en   (wr_en[i]),
      .wr_entry(wr_entry),
      .entry   (ent[i])
    );
    assign wr_en[i] = wr_go && (wr_slot == IW'(i));
  end

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = POOL_ORDERS - 1; i >= 0; i--) begin
      if (!ent[i].valid) begin
        free_found = 1'b1;
        free_slot  = IW'(i);
      end
    end
  end

  assign hit_e = ent[hit];
  assign fill  = (left < hit_e.remaining) ? left : hit_e.remaining;

  // Entry write-back after a cancel or a fill
  always_comb begin
    dec_entry = hit_e;
    if (cur.mode) begin
      dec_entry.valid = 1'b0;
    end else begin
      dec_entry.remaining = hit_e.remaining - fill;
      if (hit_e.remaining == fill) dec_entry.valid = 1'b0;
    end
  end

  assign bad_order = (req.payload.mode == MODE_NEW) &&
                     (req.payload.order_quantity == '0 || req.payload.order_ref == '0 ||
                      (req.payload.order_type == TYPE_LIMIT &&
                       req.payload.limit_price == '0));

  // Remainder rests only for a limit order on the ladder with a free slot
  assign rest_ok = (left != '0) && (cur.order_type == TYPE_LIMIT) && free_found &&
                   (32'(cur.limit_price) < 32'(PRICE_LEVELS));

  always_comb begin
    if (left == '0) final_status = ST_FILLED;
    else if (rest_ok) final_status = ST_RESTING;
    else final_status = ST_CANCELLED;
  end

  assign out_free = !out_valid || res.ready;

  // Output register loads
  always_comb begin
    case (state)
      S_IDLE:   out_load = req.valid && req.ready && bad_order;
      S_DECIDE: out_load = out_free;
      S_EMIT:   out_load = out_free && fill_report;
      S_FINAL:  out_load = out_free;
      default:  out_load = 1'b0;
    endcase
  end

  assign wr_load = ((state == S_DECIDE) && out_free) ||
                   ((state == S_FINAL) && out_free && rest_ok);

  assign req.ready   = (state == S_IDLE) && !out_valid;
  assign res.valid   = out_valid;
  assign res.payload = out;

  // Controller with entry writes and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      counter   <= '0;
      out_valid <= 1'b0;
      wr_go     <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !res.ready);
      wr_go     <= wr_load;
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur   <= req.payload;
            left  <= req.payload.order_quantity;
            n_res <= '0;
            cyc   <= '0;
            if (bad_order) begin
              out <= report_rec(req.payload.order_ref, ST_CANCELLED, req.payload.side,
                                req.payload.limit_price, '0,
                                req.payload.order_quantity, 1'b1);
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          cyc <= cyc + 1'b1;
          if (cyc == CW'(POOL_ORDERS)) begin
            hit <= chain[POOL_ORDERS].slot[IW-1:0];
            if (chain[POOL_ORDERS].found) state <= S_DECIDE;
            else if (cur.mode) state <= S_IDLE;
            else state <= S_FINAL;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            n_res    <= n_res + 1'b1;
            wr_entry <= dec_entry;
            wr_slot  <= hit;
            if (cur.mode) begin
              out <= report_rec(hit_e.order_ref, ST_CANCELLED, hit_e.side, hit_e.price,
                                hit_e.original - hit_e.remaining, hit_e.remaining, 1'b1);
              state <= S_IDLE;
            end else begin
              out <= trade_rec(cur.side ? hit_e.order_ref : cur.order_ref,
                               cur.side ? cur.order_ref : hit_e.order_ref,
                               hit_e.price, fill, cur.arrival_time);
              left        <= left - fill;
              fill_report <= (hit_e.remaining == fill);
              state       <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (fill_report) begin
              out <= report_rec(hit_e.order_ref, ST_FILLED, hit_e.side, hit_e.price,
                                hit_e.original, '0, 1'b0);
              n_res       <= n_res + 1'b1;
              fill_report <= 1'b0;
            end else begin
              cyc <= '0;
              if (left != '0 && n_res <= 6'(MAX_RESULTS - 3)) state <= S_SEARCH;
              else state <= S_FINAL;
            end
          end
        end
        S_FINAL: begin
          if (out_free) begin
            out <= report_rec(cur.order_ref, final_status, cur.side, cur.limit_price,
                              cur.order_quantity - left, left, 1'b1);
            wr_slot  <= free_slot;
            wr_entry <= '{valid: 1'b1, order_ref: cur.order_ref, side: cur.side,
                          price: cur.limit_price, original: cur.order_quantity,
                          remaining: left, rank: counter};
            state    <= S_IDLE;
            if (rest_ok) counter <= counter + 32'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OBM_ASSERT_IMP(a_no_accept_busy, state != S_IDLE, !req.ready, "accept while busy")
  `OBM_ASSERT_NEXT(a_out_hold, res.valid && !res.ready, res.valid && $stable(res.payload),
    "result dropped while stalled")
  `OBM_ASSERT_IMP(a_bound, res.valid, n_res <= 6'(MAX_RESULTS), "result bound exceeded")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import obm_pkg::*;

  localparam logic [1:0] TYPE_IOC = 2'd2;
  localparam logic [1:0] TYPE_FOK = 2'd3;
  localparam int POOL = POOL_ORDERS_DEF;
  localparam int LADDER = PRICE_LEVELS_DEF;
  localparam int RANDOM_ORDERS = 410;
  localparam int CYCLE_LIMIT = 1000000;

  // Book predictor and store of expected trades and reports
  class book_scoreboard;
    bit        live[POOL];
    bit [31:0] id_of[POOL];
    bit        side_of[POOL];
    bit [15:0] price_of[POOL];
    bit [31:0] orig_of[POOL];
    bit [31:0] rem_of[POOL];
    bit [31:0] rank_of[POOL];
    bit [31:0] seq_counter;
    result_t   expected[$];
    int        failures;

    function void clear();
      foreach (live[i]) live[i] = 0;
      seq_counter = 0;
    endfunction

    function void add_exp(result_t r);
      expected.insert(expected.size(), r);
    endfunction

    function result_t mk(bit kind, bit [31:0] buyer, bit [31:0] seller, bit [31:0] rid,
                         bit [1:0] status, bit sd, bit [15:0] price, bit [31:0] qty,
                         bit [31:0] left, bit [47:0] tstamp, bit fin);
      result_t r;
      r.record_kind = kind;   r.buyer_id = buyer;       r.seller_id = seller;
      r.report_id = rid;      r.report_status = status; r.report_side = sd;
      r.deal_price = price;   r.deal_quantity = qty;    r.left_quantity = left;
      r.trade_time = tstamp;  r.last = fin;
      return r;
    endfunction

    // Best crossing entry on the opposite side: price, then oldest arrival
    function int best_match(bit sd, bit [1:0] otype, bit [15:0] price);
      int best;
      bit [31:0] best_age, age;
      bit better;
      best = -1;
      best_age = 0;
      for (int i = 0; i < POOL; i++) begin
        if (!live[i] || side_of[i] == sd) continue;
        if (otype != TYPE_MARKET) begin
          if (sd == SIDE_BUY && price < price_of[i]) continue;
          if (sd == SIDE_SELL && price > price_of[i]) continue;
        end
        age = seq_counter - rank_of[i];
        if (best < 0) better = 1;
        else if (price_of[i] == price_of[best]) better = age > best_age;
        else if (sd == SIDE_BUY) better = price_of[i] < price_of[best];
        else better = price_of[i] > price_of[best];
        if (better) begin
          best = i;
          best_age = age;
        end
      end
      return best;
    endfunction

    function void note_request(request_t q);
      int hit, b, n, slot;
      bit [31:0] hit_age, age, left, fill;
      bit [1:0] status;
      if (q.mode == MODE_CANCEL) begin
        // newest live entry with this id
        hit = -1;
        hit_age = 0;
        for (int i = 0; i < POOL; i++) begin
          if (!live[i] || id_of[i] != q.order_ref) continue;
          age = seq_counter - rank_of[i];
          if (hit < 0 || age < hit_age) begin
            hit = i;
            hit_age = age;
          end
        end
        if (hit < 0) return;
        add_exp(mk(KIND_REPORT, 0, 0, id_of[hit], ST_CANCELLED, side_of[hit],
                   price_of[hit], orig_of[hit] - rem_of[hit], rem_of[hit], 0, 1));
        live[hit] = 0;
        return;
      end
      if (q.order_quantity == 0 || q.order_ref == 0 ||
          (q.order_type == TYPE_LIMIT && q.limit_price == 0)) begin
        add_exp(mk(KIND_REPORT, 0, 0, q.order_ref, ST_CANCELLED, q.side,
                   q.limit_price, 0, q.order_quantity, 0, 1));
        return;
      end
      // fills against the opposite side
      n = 0;
      left = q.order_quantity;
      while (left > 0 && n <= MAX_RESULTS - 3) begin
        b = best_match(q.side, q.order_type, q.limit_price);
        if (b < 0) break;
        fill = (left < rem_of[b]) ? left : rem_of[b];
        add_exp(mk(KIND_TRADE,
                   q.side == SIDE_BUY ? q.order_ref : id_of[b],
                   q.side == SIDE_BUY ? id_of[b] : q.order_ref,
                   0, ST_FILLED, 0, price_of[b], fill, 0, q.arrival_time, 0));
        n++;
        left -= fill;
        rem_of[b] -= fill;
        if (rem_of[b] == 0) begin
          add_exp(mk(KIND_REPORT, 0, 0, id_of[b], ST_FILLED, side_of[b],
                     price_of[b], orig_of[b], 0, 0, 0));
          n++;
          live[b] = 0;
        end
      end
      // remainder: rest a limit order if room and on the ladder
      if (left == 0) status = ST_FILLED;
      else if (q.order_type != TYPE_LIMIT) status = ST_CANCELLED;
      else begin
        slot = -1;
        for (int i = 0; i < POOL && slot < 0; i++)
          if (!live[i]) slot = i;
        if (slot < 0 || q.limit_price >= LADDER) status = ST_CANCELLED;
        else begin
          live[slot] = 1;
          id_of[slot] = q.order_ref;
          side_of[slot] = q.side;
          price_of[slot] = q.limit_price;
          orig_of[slot] = q.order_quantity;
          rem_of[slot] = left;
          rank_of[slot] = seq_counter;
          seq_counter += 1;
          status = ST_RESTING;
        end
      end
      add_exp(mk(KIND_REPORT, 0, 0, q.order_ref, status, q.side, q.limit_price,
                 q.order_quantity - left, left, 0, 1));
    endfunction

    function void field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (expected.size() == 0) begin
        $error("result with nothing outstanding: %p", got);
        failures++;
        return;
      end
      e = expected.pop_front();
      field("record_kind", e.record_kind, got.record_kind);
      field("buyer_id", e.buyer_id, got.buyer_id);
      field("seller_id", e.seller_id, got.seller_id);
      field("report_id", e.report_id, got.report_id);
      field("report_status", e.report_status, got.report_status);
      field("report_side", e.report_side, got.report_side);
      field("deal_price", e.deal_price, got.deal_price);
      field("deal_quantity", e.deal_quantity, got.deal_quantity);
      field("left_quantity", e.left_quantity, got.left_quantity);
      field("trade_time", e.trade_time, got.trade_time);
      field("last", e.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst;
  obm_req_if req ();
  obm_res_if res ();

  order_book_matcher dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .res (res.source)
  );

  book_scoreboard book;
  bit idle_en;
  bit hold_req;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Monitors: requests into the predictor, results against expectations
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) book.note_request(req.payload);
    if (!rst && res.valid && res.ready) book.check_result(res.payload);
  end

  // Result side back-pressure, with one long hold-off on request
  initial begin
    res.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Cycle limit
  initial begin
    for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic offer(request_t r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= r;
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic request_t order(bit [31:0] id, bit sd, bit [1:0] otype,
                                     bit [15:0] price, bit [31:0] qty, bit [47:0] ts);
    request_t r;
    r.mode = MODE_NEW;  r.order_ref = id;      r.side = sd;
    r.order_type = otype; r.limit_price = price; r.order_quantity = qty;
    r.arrival_time = ts;
    return r;
  endfunction

  function automatic request_t cancel(bit [31:0] id);
    request_t r;
    r = order(id, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 16'($urandom),
              $urandom, 48'({$urandom, $urandom}));
    r.mode = MODE_CANCEL;
    return r;
  endfunction

  // Random request: mostly a tight price band and small id pool so books cross
  function automatic request_t random_request();
    bit [31:0] id, qty;
    bit [15:0] price;
    bit [1:0] otype;
    int w;
    id = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 48);
    if ($urandom_range(0, 99) < 15) return cancel(id);
    w = $urandom_range(0, 99);
    otype = w < 55 ? TYPE_LIMIT : w < 70 ? TYPE_MARKET : w < 85 ? TYPE_IOC : TYPE_FOK;
    w = $urandom_range(0, 99);
    price = 16'(w < 80 ? $urandom_range(90, 110) : w < 90 ? $urandom_range(0, LADDER - 1)
                                                          : $urandom_range(0, 65535));
    w = $urandom_range(0, 99);
    qty = w < 2 ? 0 : w < 80 ? $urandom_range(1, 20) : w < 95 ? $urandom_range(1, 200)
                                                              : $urandom;
    return order(id, 1'($urandom_range(0, 1)), otype, price, qty,
                 48'({$urandom, $urandom}));
  endfunction

  initial begin
    book = new();
    book.clear();
    idle_en = 0;
    hold_req = 0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.payload <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: invalid orders, empty-book market, priority, IOC/FOK, ladder
    offer(order(0, SIDE_BUY, TYPE_LIMIT, 100, 5, 1));
    offer(order(1, SIDE_SELL, TYPE_LIMIT, 100, 0, 2));
    offer(order(2, SIDE_BUY, TYPE_LIMIT, 0, 5, 3));
    offer(order(3, SIDE_BUY, TYPE_MARKET, 16'hFFFF, 7, 48'hFFFF_FFFF_FFFF));
    offer(order(10, SIDE_SELL, TYPE_LIMIT, 100, 5, 4));
    offer(order(11, SIDE_SELL, TYPE_LIMIT, 100, 5, 5));
    offer(order(12, SIDE_SELL, TYPE_LIMIT, 99, 3, 6));
    offer(order(20, SIDE_BUY, TYPE_LIMIT, 100, 9, 7));
    offer(order(21, SIDE_BUY, TYPE_IOC, 101, 10, 8));
    offer(order(22, SIDE_BUY, TYPE_LIMIT, 20000, 5, 9));
    offer(order(23, SIDE_BUY, TYPE_LIMIT, LADDER - 1, 32'hFFFF_FFFF, 10));
    offer(order(24, SIDE_SELL, TYPE_FOK, 1, 10, 11));
    offer(order(30, SIDE_BUY, TYPE_LIMIT, 50, 4, 12));
    offer(order(30, SIDE_BUY, TYPE_LIMIT, 51, 4, 13));
    offer(cancel(30));
    offer(cancel(30));
    offer(cancel(30));
    offer(order(32'hFFFF_FFFF, SIDE_SELL, TYPE_MARKET, 0, 1, 48'h8000_0000_0001));
    offer(cancel(23));
    offer(order(40, SIDE_SELL, TYPE_LIMIT, 16'hFFFF, 1, 14));
    offer(order(41, SIDE_SELL, TYPE_IOC, 200, 3, 15));

    // random traffic with idling, a long result stall, then a clean tail
    idle_en = 1;
    for (int k = 0; k < RANDOM_ORDERS; k++) begin
      if (k == 150) hold_req = 1;
      if (k == RANDOM_ORDERS - 80) idle_en = 0;
      offer(random_request());
    end
    req.valid <= 1'b0;

    while (book.expected.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (book.failures == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
